@@ rtl/core/tkf_pkg.sv @@
// Package for the translation Kalman fusion unit.
// Holds register indexes, field widths and reset values; no dependencies.
package tkf_pkg;

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PV_MAX     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PV_MIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MV_MAX     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MV_MIN     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FV_LOW     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FV_HIGH    = 3'd6;

   localparam logic [15:0] RST_FULL_SCALE = 16'd1000;
   localparam logic [31:0] RST_PV_MAX     = 32'd100;
   localparam logic [31:0] RST_PV_MIN     = 32'd1;
   localparam logic [31:0] RST_MV_MAX     = 32'd100;
   localparam logic [31:0] RST_MV_MIN     = 32'd1;
   localparam logic [31:0] RST_FV_LOW     = 32'd0;
   localparam logic [31:0] RST_FV_HIGH    = 32'd10000;

   localparam int POS_W  = 64;   // Q47.16
   localparam int VAR_W  = 48;   // Q32.16
   localparam int GAIN_W = 25;   // Q0.24 including 1.0
   localparam int REM_W  = 51;
   localparam int DIV_W  = 49;
   localparam int PROD_W = 57;   // 32 x 25 product

   localparam logic [GAIN_W-1:0] GAIN_ONE = 25'h1000000;
   localparam logic [16:0]       NORM_ONE = 17'h10000;

endpackage

@@ rtl/core/translation_kalman_fusion_unit.sv @@
// Top level of the translation Kalman fusion unit: sequencer, shared multiplier
// and shared restoring divider in one module. Depends on tkf_pkg.
//
// Usage:
//  - Input channel req_*: one transaction carries the encoder and IMU
//    increments and confidences of one step. Accepted when req_valid is high
//    and req_stall is low. req_stall is high from acceptance until the result
//    transaction has been taken.
//  - Result channel rsp_*: rsp_valid stays high with a steady payload until a
//    cycle with rsp_stall low; the block then returns to idle.
//  - Configuration channel csr_*: csr_ready is always high; writes to indexes
//    above 6 are dropped. Write only while the block is idle.
//  - Sequencing: a step with no usable sensor presents its result in the
//    cycle after acceptance. Otherwise the result waits on the 16-step
//    interpolation divisions, the 24-step gain division (encoder used) and
//    the 16-step confidence division on the one shared divider, plus two
//    multiplier passes per product on the shared 32x25 multiplier.
//    Full-confidence inputs and saturated output confidence skip their
//    divisions and finish sooner.
//  - Overlap: none; a new step is accepted only once the previous result is taken.
//  - Reset: clears the estimate, variance, encoder sum, and loads the
//    register reset values; the block is idle and ready after reset.
//  - A stalled result holds the block; no new step is taken meanwhile.
module translation_kalman_fusion_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_enc_has_model,
   input  logic [15:0]                   req_enc_conf_raw,
   input  logic [15:0]                   req_enc_conf_final,
   input  logic signed [31:0]            req_enc_delta,
   input  logic                          req_imu_has_model,
   input  logic [15:0]                   req_imu_conf_raw,
   input  logic [15:0]                   req_imu_conf_final,
   input  logic signed [31:0]            req_imu_delta,
   input  logic                          req_imu_stationary,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_fused_valid,
   output logic signed [31:0]            rsp_fused_delta,
   output logic [15:0]                   rsp_fused_confidence,
   output logic                          rsp_encoder_used,
   output logic                          rsp_imu_used,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tkf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);

   // Sequencer states
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_ISTART = 5'd1;
   localparam logic [4:0] S_IDIV   = 5'd2;
   localparam logic [4:0] S_IM1    = 5'd3;
   localparam logic [4:0] S_IM2    = 5'd4;
   localparam logic [4:0] S_ISUM   = 5'd5;
   localparam logic [4:0] S_GCHK   = 5'd6;
   localparam logic [4:0] S_GDIV   = 5'd7;
   localparam logic [4:0] S_RSUB   = 5'd8;
   localparam logic [4:0] S_RABS   = 5'd9;
   localparam logic [4:0] S_RM1    = 5'd10;
   localparam logic [4:0] S_RM2    = 5'd11;
   localparam logic [4:0] S_RADD   = 5'd12;
   localparam logic [4:0] S_RUPD   = 5'd13;
   localparam logic [4:0] S_VM1    = 5'd14;
   localparam logic [4:0] S_VM2    = 5'd15;
   localparam logic [4:0] S_VSUM   = 5'd16;
   localparam logic [4:0] S_FINISH = 5'd17;
   localparam logic [4:0] S_OSAT   = 5'd18;
   localparam logic [4:0] S_CSUB   = 5'd19;
   localparam logic [4:0] S_CM1    = 5'd20;
   localparam logic [4:0] S_CM2    = 5'd21;
   localparam logic [4:0] S_CACC   = 5'd22;
   localparam logic [4:0] S_CLD    = 5'd23;
   localparam logic [4:0] S_CDIV   = 5'd24;
   localparam logic [4:0] S_OUT    = 5'd25;

   // Configuration registers
   logic [15:0] fs_ff, fs_in;
   logic [31:0] pv_max_ff, pv_max_in, pv_min_ff, pv_min_in;
   logic [31:0] mv_max_ff, mv_max_in, mv_min_ff, mv_min_in;
   logic [31:0] fv_low_ff, fv_low_in, fv_high_ff, fv_high_in;

   // Filter state
   logic [tkf_pkg::POS_W-1:0] pos_ff, pos_in, esum_ff, esum_in;
   logic [tkf_pkg::VAR_W-1:0] var_ff, var_in;

   // Sequencer and working registers
   logic [4:0]                 state_ff, state_in;
   logic                       ph_ff, ph_in;          // 0: process, 1: measurement
   logic                       enc_used_ff, enc_used_in;
   logic                       imu_used_ff, imu_used_in;
   logic [15:0]                enc_fin_ff, enc_fin_in, imu_fin_ff, imu_fin_in;
   logic [31:0]                enc_d_ff, enc_d_in;
   logic [tkf_pkg::POS_W-1:0]  s_ff, s_in, acc_ff, acc_in, mag_ff, mag_in;
   logic [tkf_pkg::VAR_W-1:0]  p_ff, p_in;
   logic                       neg_ff, neg_in;
   logic [16:0]                n_ff, n_in;
   logic [tkf_pkg::GAIN_W-1:0] k_ff, k_in;

   // Shared multiplier
   logic [31:0]                mul_a;
   logic [tkf_pkg::GAIN_W-1:0] mul_b;
   logic [tkf_pkg::PROD_W-1:0] prod_ff, prod_in;

   // Shared divider
   logic [tkf_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [tkf_pkg::DIV_W-1:0] div_ff, div_in;
   logic [15:0]               shin_ff, shin_in;
   logic [23:0]               q_ff, q_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic [tkf_pkg::REM_W-1:0] dv_rem2, dv_rem_n;
   logic                      dv_ge;
   logic [23:0]               dv_q_n;

   // Result registers
   logic        rf_valid_ff, rf_valid_in;
   logic [31:0] rf_delta_ff, rf_delta_in;
   logic [15:0] rf_conf_ff, rf_conf_in;

   // Combinational helpers
   logic        req_acc, enc_used_c, imu_used_c, hold_c;
   logic [15:0] conf_sel;
   logic [31:0] vmax_sel, vmin_sel;
   logic [48:0] ivar_sum, pvar_sum, innov_sum;
   logic [tkf_pkg::GAIN_W-1:0] om;
   logic [47:0] hi_w, lo_w, dmag;

   assign csr_ready            = 1'b1;
   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = (state_ff == S_OUT);
   assign rsp_fused_valid      = rf_valid_ff;
   assign rsp_fused_delta      = rf_delta_ff;
   assign rsp_fused_confidence = rf_conf_ff;
   assign rsp_encoder_used     = enc_used_ff;
   assign rsp_imu_used         = imu_used_ff;

   assign req_acc    = req_valid && !req_stall;
   assign enc_used_c = req_enc_has_model && (req_enc_conf_raw != 16'd0)
                       && (req_enc_conf_final != 16'd0);
   assign imu_used_c = req_imu_has_model && (req_imu_conf_raw != 16'd0)
                       && (req_imu_conf_final != 16'd0);
   // Standstill: encoder moved by at most one micrometre either way
   assign hold_c = req_imu_stationary && ((req_enc_delta == 32'sd0) ||
                   (req_enc_delta == 32'sd1) || (req_enc_delta == -32'sd1));

   assign conf_sel = ph_ff ? enc_fin_ff : (imu_used_ff ? imu_fin_ff : 16'd0);
   assign vmax_sel = ph_ff ? mv_max_ff : pv_max_ff;
   assign vmin_sel = ph_ff ? mv_min_ff : pv_min_ff;

   assign ivar_sum  = acc_ff[48:0] + prod_ff[48:0];
   assign pvar_sum  = {1'b0, var_ff} + {1'b0, ivar_sum[47:0]};
   assign innov_sum = {1'b0, p_ff} + {1'b0, ivar_sum[47:0]};
   assign om        = tkf_pkg::GAIN_ONE - k_ff;
   assign hi_w      = {fv_high_ff, 16'd0};
   assign lo_w      = {fv_low_ff, 16'd0};
   assign dmag      = acc_ff[63] ? 48'((~acc_ff + 64'd1) >> 16) : acc_ff[63:16];

   // Divider step: shift one numerator bit in, subtract when it fits
   assign dv_rem2  = {rem_ff[tkf_pkg::REM_W-2:0], shin_ff[15]};
   assign dv_ge    = (dv_rem2 >= {2'b00, div_ff});
   assign dv_rem_n = dv_ge ? (dv_rem2 - {2'b00, div_ff}) : dv_rem2;
   assign dv_q_n   = {q_ff[22:0], dv_ge};

   // Multiplier operand selection by step
   always_comb begin
      mul_a = 32'd0;
      mul_b = '0;
      unique case (state_ff)
         S_IM1: begin
            mul_a = vmax_sel;
            mul_b = tkf_pkg::GAIN_W'(tkf_pkg::NORM_ONE - n_ff);
         end
         S_IM2: begin
            mul_a = vmin_sel;
            mul_b = tkf_pkg::GAIN_W'(n_ff);
         end
         S_RM1: begin
            mul_a = mag_ff[63:32];
            mul_b = k_ff;
         end
         S_RM2: begin
            mul_a = mag_ff[31:0];
            mul_b = k_ff;
         end
         S_VM1: begin
            mul_a = {8'd0, p_ff[47:24]};
            mul_b = om;
         end
         S_VM2: begin
            mul_a = {8'd0, p_ff[23:0]};
            mul_b = om;
         end
         S_CM1: begin
            mul_a = mag_ff[31:0];
            mul_b = {9'd0, fs_ff};
         end
         S_CM2: begin
            mul_a = {16'd0, mag_ff[47:32]};
            mul_b = {9'd0, fs_ff};
         end
         default: begin
            mul_a = 32'd0;
            mul_b = '0;
         end
      endcase
      prod_in = tkf_pkg::PROD_W'(mul_a) * tkf_pkg::PROD_W'(mul_b);
   end

   // Configuration writes
   always_comb begin
      fs_in      = fs_ff;
      pv_max_in  = pv_max_ff;
      pv_min_in  = pv_min_ff;
      mv_max_in  = mv_max_ff;
      mv_min_in  = mv_min_ff;
      fv_low_in  = fv_low_ff;
      fv_high_in = fv_high_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tkf_pkg::CSR_FULL_SCALE: fs_in      = csr_data[15:0];
            tkf_pkg::CSR_PV_MAX:     pv_max_in  = csr_data;
            tkf_pkg::CSR_PV_MIN:     pv_min_in  = csr_data;
            tkf_pkg::CSR_MV_MAX:     mv_max_in  = csr_data;
            tkf_pkg::CSR_MV_MIN:     mv_min_in  = csr_data;
            tkf_pkg::CSR_FV_LOW:     fv_low_in  = csr_data;
            tkf_pkg::CSR_FV_HIGH:    fv_high_in = csr_data;
            default:                 fs_in      = fs_ff;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      ph_in       = ph_ff;
      enc_used_in = enc_used_ff;
      imu_used_in = imu_used_ff;
      enc_fin_in  = enc_fin_ff;
      imu_fin_in  = imu_fin_ff;
      enc_d_in    = enc_d_ff;
      s_in        = s_ff;
      acc_in      = acc_ff;
      mag_in      = mag_ff;
      p_in        = p_ff;
      neg_in      = neg_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      rem_in      = rem_ff;
      div_in      = div_ff;
      shin_in     = shin_ff;
      q_in        = q_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      var_in      = var_ff;
      esum_in     = esum_ff;
      rf_valid_in = rf_valid_ff;
      rf_delta_in = rf_delta_ff;
      rf_conf_in  = rf_conf_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               enc_used_in = enc_used_c;
               imu_used_in = imu_used_c;
               enc_fin_in  = req_enc_conf_final;
               imu_fin_in  = req_imu_conf_final;
               enc_d_in    = req_enc_delta;
               ph_in       = 1'b0;
               // Predict the position now; standstill holds it
               if (imu_used_c && !hold_c) begin
                  s_in = pos_ff + {{16{req_imu_delta[31]}}, req_imu_delta, 16'd0};
               end else begin
                  s_in = pos_ff;
               end
               if (!enc_used_c && !imu_used_c) begin
                  rf_valid_in = 1'b0;
                  rf_delta_in = 32'd0;
                  rf_conf_in  = 16'd0;
                  state_in    = S_OUT;
               end else begin
                  rf_valid_in = 1'b1;
                  state_in    = S_ISTART;
               end
            end
         end
         S_ISTART: begin
            if (conf_sel >= fs_ff) begin
               n_in     = tkf_pkg::NORM_ONE;
               state_in = S_IM1;
            end else begin
               rem_in   = tkf_pkg::REM_W'(conf_sel);
               div_in   = tkf_pkg::DIV_W'(fs_ff);
               shin_in  = 16'd0;
               q_in     = 24'd0;
               cnt_in   = 5'd16;
               state_in = S_IDIV;
            end
         end
         S_IDIV: begin
            rem_in  = dv_rem_n;
            q_in    = dv_q_n;
            shin_in = {shin_ff[14:0], 1'b0};
            cnt_in  = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               n_in     = {1'b0, dv_q_n[15:0]};
               state_in = S_IM1;
            end
         end
         S_IM1: begin
            state_in = S_IM2;
         end
         S_IM2: begin
            acc_in   = tkf_pkg::POS_W'(prod_ff);
            state_in = S_ISUM;
         end
         S_ISUM: begin
            if (!ph_ff) begin
               // Predicted variance saturates at the top of 48 bits
               p_in = pvar_sum[48] ? {tkf_pkg::VAR_W{1'b1}} : pvar_sum[47:0];
               if (enc_used_ff) begin
                  ph_in    = 1'b1;
                  esum_in  = esum_ff + {{16{enc_d_ff[31]}}, enc_d_ff, 16'd0};
                  state_in = S_ISTART;
               end else begin
                  state_in = S_FINISH;
               end
            end else begin
               div_in   = innov_sum;
               rem_in   = tkf_pkg::REM_W'(p_ff);
               state_in = S_GCHK;
            end
         end
         S_GCHK: begin
            if (div_ff == '0) begin
               k_in     = '0;
               state_in = S_RSUB;
            end else if (rem_ff >= {2'b00, div_ff}) begin
               k_in     = tkf_pkg::GAIN_ONE;
               state_in = S_RSUB;
            end else begin
               shin_in  = 16'd0;
               q_in     = 24'd0;
               cnt_in   = 5'd24;
               state_in = S_GDIV;
            end
         end
         S_GDIV: begin
            rem_in  = dv_rem_n;
            q_in    = dv_q_n;
            shin_in = {shin_ff[14:0], 1'b0};
            cnt_in  = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               k_in     = {1'b0, dv_q_n};
               state_in = S_RSUB;
            end
         end
         S_RSUB: begin
            acc_in   = esum_ff - s_ff;
            state_in = S_RABS;
         end
         S_RABS: begin
            neg_in   = acc_ff[63];
            mag_in   = acc_ff[63] ? (~acc_ff + 64'd1) : acc_ff;
            state_in = S_RM1;
         end
         S_RM1: begin
            state_in = S_RM2;
         end
         S_RM2: begin
            acc_in   = {prod_ff[55:0], 8'd0};
            state_in = S_RADD;
         end
         S_RADD: begin
            acc_in   = acc_ff + tkf_pkg::POS_W'(prod_ff >> 24);
            state_in = S_RUPD;
         end
         S_RUPD: begin
            s_in     = neg_ff ? (s_ff - acc_ff) : (s_ff + acc_ff);
            state_in = S_VM1;
         end
         S_VM1: begin
            state_in = S_VM2;
         end
         S_VM2: begin
            acc_in   = tkf_pkg::POS_W'(prod_ff);
            state_in = S_VSUM;
         end
         S_VSUM: begin
            p_in     = 48'(acc_ff + tkf_pkg::POS_W'(prod_ff >> 24));
            state_in = S_FINISH;
         end
         S_FINISH: begin
            pos_in   = s_ff;
            var_in   = p_ff;
            acc_in   = s_ff - pos_ff;
            state_in = S_OSAT;
         end
         S_OSAT: begin
            // Truncate toward zero, then saturate to 32 bits
            if (acc_ff[63]) begin
               rf_delta_in = (dmag > 48'h80000000) ? 32'h80000000 : 32'(~dmag + 48'd1);
            end else begin
               rf_delta_in = (dmag > 48'h7FFFFFFF) ? 32'h7FFFFFFF : dmag[31:0];
            end
            if ((fv_high_ff <= fv_low_ff) || (p_ff <= lo_w)) begin
               rf_conf_in = fs_ff;
               state_in   = S_OUT;
            end else if (p_ff >= hi_w) begin
               rf_conf_in = 16'd0;
               state_in   = S_OUT;
            end else begin
               state_in = S_CSUB;
            end
         end
         S_CSUB: begin
            mag_in   = {16'd0, hi_w - p_ff};
            div_in   = {1'b0, hi_w - lo_w};
            state_in = S_CM1;
         end
         S_CM1: begin
            state_in = S_CM2;
         end
         S_CM2: begin
            acc_in   = tkf_pkg::POS_W'(prod_ff);
            state_in = S_CACC;
         end
         S_CACC: begin
            acc_in   = acc_ff + {prod_ff[31:0], 32'd0};
            state_in = S_CLD;
         end
         S_CLD: begin
            rem_in   = tkf_pkg::REM_W'(acc_ff[63:16]);
            shin_in  = acc_ff[15:0];
            q_in     = 24'd0;
            cnt_in   = 5'd16;
            state_in = S_CDIV;
         end
         S_CDIV: begin
            rem_in  = dv_rem_n;
            q_in    = dv_q_n;
            shin_in = {shin_ff[14:0], 1'b0};
            cnt_in  = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               rf_conf_in = dv_q_n[15:0];
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            // Hold the result until the receiver takes it
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fs_ff       <= tkf_pkg::RST_FULL_SCALE;
         pv_max_ff   <= tkf_pkg::RST_PV_MAX;
         pv_min_ff   <= tkf_pkg::RST_PV_MIN;
         mv_max_ff   <= tkf_pkg::RST_MV_MAX;
         mv_min_ff   <= tkf_pkg::RST_MV_MIN;
         fv_low_ff   <= tkf_pkg::RST_FV_LOW;
         fv_high_ff  <= tkf_pkg::RST_FV_HIGH;
         pos_ff      <= '0;
         var_ff      <= '0;
         esum_ff     <= '0;
         ph_ff       <= 1'b0;
         cnt_ff      <= 5'd0;
         enc_used_ff <= 1'b0;
         imu_used_ff <= 1'b0;
         rf_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fs_ff       <= fs_in;
         pv_max_ff   <= pv_max_in;
         pv_min_ff   <= pv_min_in;
         mv_max_ff   <= mv_max_in;
         mv_min_ff   <= mv_min_in;
         fv_low_ff   <= fv_low_in;
         fv_high_ff  <= fv_high_in;
         pos_ff      <= pos_in;
         var_ff      <= var_in;
         esum_ff     <= esum_in;
         ph_ff       <= ph_in;
         cnt_ff      <= cnt_in;
         enc_used_ff <= enc_used_in;
         imu_used_ff <= imu_used_in;
         rf_valid_ff <= rf_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      enc_fin_ff  <= enc_fin_in;
      imu_fin_ff  <= imu_fin_in;
      enc_d_ff    <= enc_d_in;
      s_ff        <= s_in;
      acc_ff      <= acc_in;
      mag_ff      <= mag_in;
      p_ff        <= p_in;
      neg_ff      <= neg_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      shin_ff     <= shin_in;
      q_ff        <= q_in;
      rf_delta_ff <= rf_delta_in;
      rf_conf_ff  <= rf_conf_in;
   end

`ifndef SYNTH
   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("result pending while block is idle");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fused_valid) |->
      (!rsp_encoder_used && !rsp_imu_used && rsp_fused_delta == 32'sd0))
      else $error("empty result carries data");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GDIV || state_ff == S_CDIV) |-> (rem_ff < {2'b00, div_ff}))
      else $error("divider remainder not below divisor");

   a_used_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fused_valid) |-> (rsp_encoder_used || rsp_imu_used))
      else $error("fused result with no sensor used");

   a_out_leaves: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result repeated after it was taken");
`endif

endmodule

@@ test/kalman_fusion_checker.sv @@
// Scoreboard for the translation Kalman fusion unit: watches the csr, req and
// rsp channels, predicts every fused transaction and compares it field by field.
// Depends on tkf_pkg for register indexes and reset values.
module kalman_fusion_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_enc_has_model,
   input  logic [15:0]                   req_enc_conf_raw,
   input  logic [15:0]                   req_enc_conf_final,
   input  logic [31:0]                   req_enc_delta,
   input  logic                          req_imu_has_model,
   input  logic [15:0]                   req_imu_conf_raw,
   input  logic [15:0]                   req_imu_conf_final,
   input  logic [31:0]                   req_imu_delta,
   input  logic                          req_imu_stationary,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_fused_valid,
   input  logic [31:0]                   rsp_fused_delta,
   input  logic [15:0]                   rsp_fused_confidence,
   input  logic                          rsp_encoder_used,
   input  logic                          rsp_imu_used,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [tkf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data,
   output int                            fail_count,
   output int                            pending,
   output int                            fused_seen
);

   localparam logic [63:0] VAR_SAT = 64'hFFFF_FFFF_FFFF;
   localparam logic [63:0] Q24_ONE = 64'h100_0000;

   typedef struct packed {
      logic        fused_valid;
      logic [31:0] fused_delta;
      logic [15:0] fused_conf;
      logic        enc_used;
      logic        imu_used;
   } fused_type;

   fused_type fused_q[$];

   logic [15:0] full_scale;
   logic [31:0] pv_max, pv_min, mv_max, mv_min, fv_low, fv_high;
   logic [63:0] position, enc_sum;
   logic [47:0] variance;

   function automatic logic [63:0] blend_var(input logic [15:0] conf,
                                             input logic [31:0] vmax, input logic [31:0] vmin);
      logic [63:0] n;
      if (conf >= full_scale) n = 64'd65536;
      else n = ({48'd0, conf} << 16) / {48'd0, full_scale};
      return ({32'd0, vmax} << 16) - n * ({32'd0, vmax} - {32'd0, vmin});
   endfunction

   function automatic logic [63:0] blend_weight(input logic [63:0] p, input logic [63:0] sum);
      logic [127:0] q;
      if (sum == 0) return 64'd0;
      if (p >= sum) return Q24_ONE;
      q = ({64'd0, p} << 24) / {64'd0, sum};
      return q[63:0];
   endfunction

   function automatic logic [63:0] var_confidence(input logic [63:0] p);
      logic [63:0] lo, hi;
      lo = {32'd0, fv_low} << 16;
      hi = {32'd0, fv_high} << 16;
      if (fv_high <= fv_low || p <= lo) return {48'd0, full_scale};
      if (p >= hi) return 64'd0;
      return ((hi - p) * {48'd0, full_scale}) / (hi - lo);
   endfunction

   // Advance the filter by one step and return the fused transaction it yields.
   function automatic fused_type fuse_step();
      fused_type   r;
      logic        enc_on, imu_on;
      logic [63:0] enc, imu, s, p, mv, k, res, mag, corr, one_m, d;
      r = '0;
      enc_on = req_enc_has_model && req_enc_conf_raw != 0 && req_enc_conf_final != 0;
      imu_on = req_imu_has_model && req_imu_conf_raw != 0 && req_imu_conf_final != 0;
      if (!enc_on && !imu_on) return r;
      enc = {{32{req_enc_delta[31]}}, req_enc_delta};
      imu = {{32{req_imu_delta[31]}}, req_imu_delta};
      s = position;
      if (imu_on) s = position + (imu << 16);
      if (req_imu_stationary &&
          (req_enc_delta <= 32'd1 || req_enc_delta == 32'hFFFF_FFFF)) s = position;
      p = {16'd0, variance} + blend_var(imu_on ? req_imu_conf_final : 16'd0, pv_max, pv_min);
      if (p > VAR_SAT) p = VAR_SAT;
      if (enc_on) begin
         enc_sum = enc_sum + (enc << 16);
         mv = blend_var(req_enc_conf_final, mv_max, mv_min);
         k = blend_weight(p, p + mv);
         res = enc_sum - s;
         mag = res[63] ? (64'd0 - res) : res;
         corr = (((mag >> 32) * k) << 8) + (((mag & 64'hFFFF_FFFF) * k) >> 24);
         s = res[63] ? s - corr : s + corr;
         one_m = Q24_ONE - k;
         p = one_m * (p >> 24) + ((one_m * (p & 64'hFF_FFFF)) >> 24);
      end
      d = s - position;
      position = s;
      variance = p[47:0];
      if (d[63]) begin
         mag = (64'd0 - d) >> 16;
         r.fused_delta = (mag > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
      end else begin
         mag = d >> 16;
         r.fused_delta = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end
      r.fused_valid = 1'b1;
      r.fused_conf  = 16'(var_confidence({16'd0, variance}));
      r.enc_used    = enc_on;
      r.imu_used    = imu_on;
      return r;
   endfunction

   always @(posedge clock) begin
      fused_type want;
      int        errs;
      if (reset) begin
         full_scale = tkf_pkg::RST_FULL_SCALE;
         pv_max = tkf_pkg::RST_PV_MAX;   pv_min = tkf_pkg::RST_PV_MIN;
         mv_max = tkf_pkg::RST_MV_MAX;   mv_min = tkf_pkg::RST_MV_MIN;
         fv_low = tkf_pkg::RST_FV_LOW;   fv_high = tkf_pkg::RST_FV_HIGH;
         position = '0; variance = '0; enc_sum = '0;
         fused_q.delete();
         fail_count <= 0;
         fused_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tkf_pkg::CSR_FULL_SCALE: full_scale = csr_data[15:0];
               tkf_pkg::CSR_PV_MAX:     pv_max = csr_data;
               tkf_pkg::CSR_PV_MIN:     pv_min = csr_data;
               tkf_pkg::CSR_MV_MAX:     mv_max = csr_data;
               tkf_pkg::CSR_MV_MIN:     mv_min = csr_data;
               tkf_pkg::CSR_FV_LOW:     fv_low = csr_data;
               tkf_pkg::CSR_FV_HIGH:    fv_high = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) fused_q.push_back(fuse_step());
         if (rsp_valid && !rsp_stall) begin
            errs = 0;
            if (fused_q.size() == 0) begin
               $display("%0t: unexpected fused transaction, delta %0d", $time,
                        $signed(rsp_fused_delta));
               errs = 1;
            end else begin
               want = fused_q.pop_front();
               if (rsp_fused_valid !== want.fused_valid) begin
                  $display("%0t: fused_valid exp %0d got %0d", $time,
                           want.fused_valid, rsp_fused_valid);
                  errs++;
               end
               if (rsp_fused_delta !== want.fused_delta) begin
                  $display("%0t: fused_delta exp %0d got %0d", $time,
                           $signed(want.fused_delta), $signed(rsp_fused_delta));
                  errs++;
               end
               if (rsp_fused_confidence !== want.fused_conf) begin
                  $display("%0t: fused_confidence exp %0d got %0d", $time,
                           want.fused_conf, rsp_fused_confidence);
                  errs++;
               end
               if (rsp_encoder_used !== want.enc_used) begin
                  $display("%0t: encoder_used exp %0d got %0d", $time,
                           want.enc_used, rsp_encoder_used);
                  errs++;
               end
               if (rsp_imu_used !== want.imu_used) begin
                  $display("%0t: imu_used exp %0d got %0d", $time,
                           want.imu_used, rsp_imu_used);
                  errs++;
               end
            end
            fail_count <= fail_count + errs;
            fused_seen <= fused_seen + 1;
         end
      end
      pending <= fused_q.size();
   end

endmodule

@@ test/testbench.sv @@
// Top of the translation Kalman fusion testbench: clock, reset, stimulus,
// receiver stalls and verdict. Depends on tkf_pkg, the unit and kalman_fusion_checker.
module testbench;

   localparam int RUN_LIMIT = 2000000;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic        req_enc_has_model, req_imu_has_model, req_imu_stationary;
   logic [15:0] req_enc_conf_raw, req_enc_conf_final, req_imu_conf_raw, req_imu_conf_final;
   logic signed [31:0] req_enc_delta, req_imu_delta;
   logic        rsp_valid, rsp_stall;
   logic        rsp_fused_valid, rsp_encoder_used, rsp_imu_used;
   logic signed [31:0] rsp_fused_delta;
   logic [15:0] rsp_fused_confidence;
   logic        csr_valid, csr_ready;
   logic [tkf_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_data;

   int fail_count, pending, fused_seen;
   int burst_left, items_sent, cycle_count;
   bit long_hold;   // ask the receiver for one long hold-off

   translation_kalman_fusion_unit uut (.*);

   kalman_fusion_checker scoreboard (.*);

   // Free-running clock, period 10.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: end the run if the traffic never drains.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("translation_kalman_fusion_unit: mismatch");
         $finish;
      end
   end

   // Receiver: cycle through stall patterns in windows, with one long hold-off
   // on request so the unit backs up and stalls its input.
   initial begin
      int window, mode;
      rsp_stall = 1'b0;
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         mode = $urandom_range(0, 3);
         for (window = 0; window < 150; window++) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ($urandom_range(0, 1) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Offer one step and hold it until taken; drop valid only at a burst end.
   task automatic send_step(input int unsigned enc_m, input int unsigned enc_raw,
                            input int unsigned enc_fin, input int unsigned enc_d,
                            input int unsigned imu_m, input int unsigned imu_raw,
                            input int unsigned imu_fin, input int unsigned imu_d,
                            input int unsigned stat);
      req_enc_has_model  <= enc_m[0];
      req_enc_conf_raw   <= enc_raw[15:0];
      req_enc_conf_final <= enc_fin[15:0];
      req_enc_delta      <= enc_d;
      req_imu_has_model  <= imu_m[0];
      req_imu_conf_raw   <= imu_raw[15:0];
      req_imu_conf_final <= imu_fin[15:0];
      req_imu_delta      <= imu_d;
      req_imu_stationary <= stat[0];
      req_valid          <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
   endtask

   // Stop offering and wait until every fused transaction has come back.
   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_reg(input logic [tkf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic load_regs(input logic [15:0] fs, input logic [31:0] pmax, input logic [31:0] pmin,
                            input logic [31:0] mmax, input logic [31:0] mmin,
                            input logic [31:0] flo, input logic [31:0] fhi);
      write_reg(tkf_pkg::CSR_FULL_SCALE, {16'd0, fs});
      write_reg(tkf_pkg::CSR_PV_MAX, pmax);
      write_reg(tkf_pkg::CSR_PV_MIN, pmin);
      write_reg(tkf_pkg::CSR_MV_MAX, mmax);
      write_reg(tkf_pkg::CSR_MV_MIN, mmin);
      write_reg(tkf_pkg::CSR_FV_LOW, flo);
      write_reg(tkf_pkg::CSR_FV_HIGH, fhi);
   endtask

   // Random steps: mostly both sensors healthy with moderate motion, some
   // standstill, some with one sensor dropped, and some pure noise.
   task automatic random_steps(input int count);
      int          i, kind;
      logic [31:0] enc_d, imu_d;
      for (i = 0; i < count; i++) begin
         kind = $urandom_range(0, 99);
         imu_d = $urandom_range(0, 4000) - 2000;
         enc_d = imu_d + $urandom_range(0, 200) - 100;
         if (kind < 55)
            send_step(1, $urandom_range(1, 65535), $urandom_range(1, 2000), enc_d,
                      1, $urandom_range(1, 65535), $urandom_range(1, 2000), imu_d, 0);
         else if (kind < 67)
            send_step(1, $urandom_range(1, 65535), $urandom_range(1, 65535),
                      $urandom_range(0, 2) - 1, 1, $urandom_range(1, 65535),
                      $urandom_range(1, 65535), imu_d, 1);
         else if (kind < 75)
            send_step(1, $urandom_range(1, 65535), $urandom_range(1, 65535), enc_d,
                      $urandom_range(0, 1), $urandom_range(0, 1), 0, imu_d,
                      $urandom_range(0, 1));
         else if (kind < 83)
            send_step($urandom_range(0, 1), $urandom_range(0, 1), 0, enc_d,
                      1, $urandom_range(1, 65535), $urandom_range(1, 65535), imu_d,
                      $urandom_range(0, 1));
         else
            send_step($urandom_range(0, 1), $urandom(), $urandom(), $urandom(),
                      $urandom_range(0, 1), $urandom(), $urandom(), $urandom(),
                      $urandom_range(0, 1));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_enc_has_model = 1'b0; req_enc_conf_raw = '0; req_enc_conf_final = '0;
      req_enc_delta = '0; req_imu_has_model = 1'b0; req_imu_conf_raw = '0;
      req_imu_conf_final = '0; req_imu_delta = '0; req_imu_stationary = 1'b0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      cycle_count = 0; items_sent = 0; long_hold = 1'b0;
      burst_left = 4;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset configuration, extremes and special cases.
      send_step(0, 0, 0, 0, 0, 0, 0, 0, 0);                             // nothing present
      send_step(1, 0, 5, 100, 1, 500, 0, 100, 0);                        // raw zero, final zero
      send_step(1, 16'hFFFF, 0, 7, 1, 16'hFFFF, 16'hFFFF, 7, 0);         // IMU only
      send_step(1, 16'hFFFF, 16'hFFFF, 9, 0, 16'hFFFF, 16'hFFFF, 9, 0);  // encoder only
      send_step(1, 500, 500, 32'h7FFF_FFFF, 1, 500, 500, 32'h7FFF_FFFF, 0);
      send_step(1, 500, 500, 32'h8000_0000, 1, 500, 500, 32'h8000_0000, 0);
      send_step(1, 1, 1, 32'h8000_0000, 1, 1, 1, 32'h7FFF_FFFF, 0);
      send_step(1, 900, 900, 0, 1, 900, 900, 1234, 1);                    // standstill hold
      send_step(1, 900, 900, 1, 1, 900, 900, -77, 1);
      send_step(1, 900, 900, -1, 1, 900, 900, 55, 1);
      send_step(1, 900, 900, 2, 1, 900, 900, 55, 1);                      // hold not taken
      send_step(1, 900, 900, -2, 1, 900, 900, 55, 1);
      send_step(1, 900, 900, 0, 0, 900, 900, 55, 1);                      // hold, IMU unused
      send_step(1, 999, 1000, 10, 1, 1001, 999, 10, 0);                   // around full scale
      send_step(1, 65535, 65535, 32'hFFFF_FFFF, 1, 65535, 65535, 32'hFFFF_FFFF, 0);
      send_step(0, 65535, 65535, 50, 1, 65535, 65535, 50, 0);
      send_step(1, 65535, 65535, 50, 0, 65535, 65535, 50, 0);
      send_step(1, 16'h5555, 16'hAAAA, 32'h5555_5555, 1, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 1);

      // Long receiver hold-off while the sender keeps offering.
      long_hold = 1'b1;
      random_steps(10);
      random_steps(140);
      drain();   // sender pauses until every result is back

      load_regs(16'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
      send_step(1, 1, 1, 3, 1, 1, 1, 3, 0);
      random_steps(140);
      drain();

      load_regs(16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      random_steps(140);
      drain();

      load_regs(16'($urandom_range(1, 65535)), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom_range(0, 1000), $urandom());
      random_steps(140);
      drain();

      load_regs(16'd1000, 32'd5000, 32'd10, 32'd200, 32'd3, 32'd100, 32'd40000000);
      random_steps(140);
      drain();

      $display("Sent %0d steps over five register settings, %0d fused results checked.",
               items_sent, fused_seen);
      if (fail_count == 0)
         $display("translation_kalman_fusion_unit: match");
      else
         $display("translation_kalman_fusion_unit: mismatch");
      $finish;
   end

endmodule
